// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic                    load;
    logic                    enq;
    logic signed [VAL_W-1:0] item_value;
    logic signed [PRI_W-1:0] item_priority;
  } spq_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
module spq_cell (
  input  wire logic                            clk,
  input  wire spq_pkg::spq_ctrl_t              ctrl,
  input  wire logic                            occupied,
  input  wire logic                            left_ge,
  input  wire logic signed [spq_pkg::VAL_W-1:0] left_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0] left_priority,
  input  wire logic signed [spq_pkg::VAL_W-1:0] right_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0] right_priority,
  output logic                                 ge,
  output logic signed [spq_pkg::VAL_W-1:0]     value,
  output logic signed [spq_pkg::PRI_W-1:0]     priority_o
);
  import spq_pkg::*;

  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic signed [PRI_W-1:0] prio_r, prio_nxt;

  // held entry stays ahead of a new one of equal priority
  assign ge         = occupied && (prio_r >= ctrl.item_priority);
  assign value      = value_r;
  assign priority_o = prio_r;

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctrl.load) begin
      if (ctrl.enq) begin
        if (ge) begin
          value_nxt = value_r;
          prio_nxt  = prio_r;
        end else if (left_ge) begin
          value_nxt = ctrl.item_value;
          prio_nxt  = ctrl.item_priority;
        end else begin
          value_nxt = left_value;
          prio_nxt  = left_priority;
        end
      end else begin
        value_nxt = right_value;
        prio_nxt  = right_priority;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/stable_priority_queue_unit.sv -----
`default_nettype none
`include "assert_macros.svh"
// Stable priority queue of up to CAPACITY (value, priority) entries held in a
// row of cells sorted from highest to lowest priority, head in cell 0. Every
// cell compares its priority with the incoming one in parallel and shifts by
// one place toward the tail on enqueue or toward the head on dequeue, and
// one word is taken every cycle while the result register is free or being
// drained. Each word yields one result word, registered, carrying status,
// the removed entry on a dequeue and the occupancy after the operation.
// Equal priorities leave in arrival order.
module stable_priority_queue_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_cmd,
  input  wire logic signed [spq_pkg::VAL_W-1:0] in_item_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0] in_item_priority,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_status,
  output logic signed [spq_pkg::VAL_W-1:0]      out_value,
  output logic signed [spq_pkg::PRI_W-1:0]      out_priority,
  output logic [spq_pkg::OCC_W-1:0]             out_occupancy
);
  import spq_pkg::*;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 status_r, status_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic signed [PRI_W-1:0] prio_r, prio_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt;

  logic                    accept, full, empty;
  spq_ctrl_t               ctrl;
  logic                    ge     [CAPACITY];
  logic signed [VAL_W-1:0] cell_v [CAPACITY];
  logic signed [PRI_W-1:0] cell_p [CAPACITY];

  logic                    deq_go, enq_drop, nondeq_res, zero_payload;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  always_comb begin
    ctrl.enq           = (in_cmd == CMD_ENQ);
    ctrl.item_value    = in_item_value;
    ctrl.item_priority = in_item_priority;
    ctrl.load          = accept && (ctrl.enq ? !full : !empty);
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    l_ge;
      logic signed [VAL_W-1:0] l_v, r_v;
      logic signed [PRI_W-1:0] l_p, r_p;
      if (i == 0) begin : g_head
        assign l_ge = 1'b1;
        assign l_v  = in_item_value;
        assign l_p  = in_item_priority;
      end else begin : g_body
        assign l_ge = ge[i-1];
        assign l_v  = cell_v[i-1];
        assign l_p  = cell_p[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign r_v = cell_v[i];
        assign r_p = cell_p[i];
      end else begin : g_mid
        assign r_v = cell_v[i+1];
        assign r_p = cell_p[i+1];
      end
      spq_cell u_cell (
        .clk            (clk),
        .ctrl           (ctrl),
        .occupied       (count_r > CNT_W'(i)),
        .left_ge        (l_ge),
        .left_value     (l_v),
        .left_priority  (l_p),
        .right_value    (r_v),
        .right_priority (r_p),
        .ge             (ge[i]),
        .value          (cell_v[i]),
        .priority_o     (cell_p[i])
      );
    end
  endgenerate

  // next count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.load) begin
      if (ctrl.enq) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // result word
  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    value_nxt     = value_r;
    prio_nxt      = prio_r;
    occ_nxt       = occ_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      value_nxt     = '0;
      prio_nxt      = '0;
      occ_nxt       = OCC_W'(count_nxt);
      if (ctrl.enq) begin
        status_nxt = full ? ST_FULL : ST_ENQ;
      end else if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        status_nxt = ST_DEQ;
        value_nxt  = cell_v[0];
        prio_nxt   = cell_p[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    status_r <= status_nxt;
    value_r  <= value_nxt;
    prio_r   <= prio_nxt;
    occ_r    <= occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_value     = value_r;
  assign out_priority  = prio_r;
  assign out_occupancy = occ_r;

  assign deq_go       = ctrl.load && !ctrl.enq;
  assign enq_drop     = accept && ctrl.enq && full;
  assign nondeq_res   = out_valid && (out_status != ST_DEQ);
  assign zero_payload = (out_value == '0) && (out_priority == '0);

  `SPQ_ASSERT_ALWAYS(a_count_bound, !rst_n || count_r <= CNT_W'(CAPACITY), "count beyond capacity")
  `SPQ_ASSERT(a_deq_count, deq_go |=> (count_r == $past(count_r) - CNT_W'(1)), "bad dequeue")
  `SPQ_ASSERT(a_full_drop, enq_drop |=> (out_status == ST_FULL && $stable(count_r)), "no drop")
  `SPQ_ASSERT(a_zero_payload, nondeq_res |-> zero_payload, "payload set without dequeue")

endmodule
`default_nettype wire
